// ===== src/tst_pkg.sv =====
// shared types and constants for the typed symbol table
`timescale 1ns / 1ps
`default_nettype none

package tst_pkg;

   // default number of table entries
   localparam int TABLE_DEPTH_DEF = 64;

   // fixed field widths
   localparam int KEY_W   = 64;
   localparam int VALUE_W = 32;
   localparam int SLOT_W  = 6;
   localparam int ERR_W   = 16;

   localparam logic [ERR_W-1:0] ERR_MAX = '1;

   // request function codes
   typedef enum logic [2:0] {
      FN_DECLARE    = 3'd0,
      FN_ASSIGN_INT = 3'd1,
      FN_ASSIGN_STR = 3'd2,
      FN_READ_INT   = 3'd3,
      FN_READ_STR   = 3'd4,
      FN_TYPE       = 3'd5
   } func_type;

   // response status codes
   typedef enum logic [2:0] {
      RS_OK        = 3'd0,
      RS_REDECL    = 3'd1,
      RS_FULL      = 3'd2,
      RS_UNDECL    = 3'd3,
      RS_MISMATCH  = 3'd4,
      RS_CONST_SET = 3'd5
   } status_type;

   // one table entry as held in the entry memory
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic               is_constant;
      logic               is_integer;
      logic               fresh;
      logic [VALUE_W-1:0] value;
   } entry_type;

   // controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SETTLE,
      S_COMMIT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic skip_scan;
      logic scan_last;
      logic out_busy;
   } stat_type;

endpackage

`default_nettype wire

// ===== src/typed_symbol_table.sv =====
// top level of the typed symbol table
//
// One request carries a function code, a packed 64-bit key, declare flags and
// an integer value; each request gives exactly one response with status,
// read value, slot, type flag and the running semantic error total.
// Both channels use valid and stall; a transfer happens on a rising edge with
// valid high and stall low.
// A request is matched against the declared entries by reading the entry
// memory one entry per cycle through its single read port. A request passes
// through load, a scan of the declared entries (skipped when the table is empty
// or the code is unused), a settle step and a commit step, and one request is
// in work at a time.
// A new request is taken while the previous response still waits in the
// output register; the commit step waits while that register is held by
// rsp_stall, and req_stall stays high until then.
// Synchronous reset empties the table and clears the error total at once;
// entry contents are not cleared and are never read before being declared.
`timescale 1ns / 1ps
`default_nettype none

module typed_symbol_table #(
   parameter int TABLE_DEPTH = tst_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [2:0]                         req_func,
   input  wire logic [tst_pkg::KEY_W-1:0]          req_key,
   input  wire logic                               req_is_constant,
   input  wire logic                               req_is_integer,
   input  wire logic signed [tst_pkg::VALUE_W-1:0] req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [2:0]                              rsp_status,
   output logic signed [tst_pkg::VALUE_W-1:0]      rsp_value_out,
   output logic [tst_pkg::SLOT_W-1:0]              rsp_slot,
   output logic                                    rsp_type_out,
   output logic [tst_pkg::ERR_W-1:0]               rsp_error_total
);

   tst_pkg::cmd_type  cmd;
   tst_pkg::stat_type stat;

   // sequencer
   tst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table storage and update
   tst_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_is_constant (req_is_constant),
      .req_is_integer  (req_is_integer),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .rsp_slot        (rsp_slot),
      .rsp_type_out    (rsp_type_out),
      .rsp_error_total (rsp_error_total)
   );

endmodule

`default_nettype wire

// ===== src/tst_ctrl.sv =====
// controller state machine for the typed symbol table
`timescale 1ns / 1ps
`default_nettype none

module tst_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tst_pkg::stat_type stat,
   output tst_pkg::cmd_type       cmd
);

   tst_pkg::state_type state_ff;
   tst_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tst_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         tst_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = stat.skip_scan ? tst_pkg::S_SETTLE : tst_pkg::S_SCAN;
            end
         end
         tst_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_last) begin
               state_in = tst_pkg::S_SETTLE;
            end
         end
         tst_pkg::S_SETTLE: begin
            state_in = tst_pkg::S_COMMIT;
         end
         tst_pkg::S_COMMIT: begin
            if (!stat.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = tst_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tst_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== src/tst_datapath.sv =====
// entry memory, key match, update logic and response register
`timescale 1ns / 1ps
`default_nettype none

module tst_datapath #(
   parameter int TABLE_DEPTH = tst_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tst_pkg::cmd_type              cmd,
   output tst_pkg::stat_type                  stat,
   input  wire logic [2:0]                    req_func,
   input  wire logic [tst_pkg::KEY_W-1:0]     req_key,
   input  wire logic                          req_is_constant,
   input  wire logic                          req_is_integer,
   input  wire logic signed [tst_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [2:0]                         rsp_status,
   output logic signed [tst_pkg::VALUE_W-1:0] rsp_value_out,
   output logic [tst_pkg::SLOT_W-1:0]         rsp_slot,
   output logic                               rsp_type_out,
   output logic [tst_pkg::ERR_W-1:0]          rsp_error_total
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = (IW > tst_pkg::SLOT_W) ? IW : tst_pkg::SLOT_W;

   tst_pkg::entry_type mem [TABLE_DEPTH];

   // latched request
   logic [2:0]                  func_ff;
   logic [tst_pkg::KEY_W-1:0]   key_ff;
   logic                        const_ff;
   logic                        int_ff;
   logic [tst_pkg::VALUE_W-1:0] value_ff;

   // scan state
   logic [IW-1:0]      scan_ptr_ff;
   logic [IW-1:0]      scan_ptr_in;
   tst_pkg::entry_type rd_data_ff;
   logic [IW-1:0]      rd_addr_ff;
   logic               chk_ff;
   logic               found_ff;
   logic [IW-1:0]      match_idx_ff;
   tst_pkg::entry_type match_ff;

   // table counters
   logic [CW-1:0]             count_ff;
   logic [tst_pkg::ERR_W-1:0] err_ff;
   logic [tst_pkg::ERR_W-1:0] err_in;

   // response register
   logic                               rsp_valid_ff;
   logic [2:0]                         rsp_status_ff;
   logic [tst_pkg::VALUE_W-1:0]        rsp_value_ff;
   logic [tst_pkg::SLOT_W-1:0]         rsp_slot_ff;
   logic                               rsp_type_ff;
   logic [tst_pkg::ERR_W-1:0]          rsp_err_ff;

   // decision outputs
   tst_pkg::status_type         status;
   logic [tst_pkg::VALUE_W-1:0] vout;
   logic [SW-1:0]               slot_wide;
   logic                        tout;
   logic                        err_flag;
   logic                        wr_en;
   logic [IW-1:0]               wr_addr;
   tst_pkg::entry_type          wr_data;
   logic                        cnt_inc;
   logic                        full;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         key_ff   <= req_key;
         const_ff <= req_is_constant;
         int_ff   <= req_is_integer;
         value_ff <= $unsigned(req_value);
      end
   end

   // scan pointer and read pipeline flag
   assign scan_ptr_in = scan_ptr_ff + IW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ptr_ff <= '0;
         chk_ff      <= 1'b0;
      end else begin
         chk_ff <= cmd.scan;
         if (cmd.load) begin
            scan_ptr_ff <= '0;
         end else if (cmd.scan) begin
            scan_ptr_ff <= scan_ptr_in;
         end
      end
   end

   // entry memory: one registered read, one write
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         rd_data_ff <= mem[scan_ptr_ff];
         rd_addr_ff <= scan_ptr_ff;
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // key compare, lowest matching index wins
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.load) begin
         found_ff <= 1'b0;
      end else if (chk_ff && !found_ff && (rd_data_ff.key == key_ff)) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (chk_ff && !found_ff && (rd_data_ff.key == key_ff)) begin
         match_idx_ff <= rd_addr_ff;
         match_ff     <= rd_data_ff;
      end
   end

   // status toward the controller
   always_comb begin
      stat.skip_scan = (count_ff == '0) || (req_func > tst_pkg::FN_TYPE);
      stat.scan_last = ((CW'(scan_ptr_ff) + CW'(1)) == count_ff);
      stat.out_busy  = rsp_valid_ff && rsp_stall;
   end

   assign full = (count_ff == CW'(TABLE_DEPTH));

   // operation decision and entry update
   always_comb begin
      status    = tst_pkg::RS_OK;
      vout      = '0;
      slot_wide = found_ff ? SW'(match_idx_ff) : '0;
      tout      = 1'b0;
      err_flag  = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = match_idx_ff;
      wr_data   = match_ff;
      cnt_inc   = 1'b0;
      unique case (tst_pkg::func_type'(func_ff)) inside
         tst_pkg::FN_DECLARE: begin
            if (found_ff) begin
               status   = tst_pkg::RS_REDECL;
               err_flag = 1'b1;
            end else if (full) begin
               status = tst_pkg::RS_FULL;
            end else begin
               wr_en               = cmd.commit;
               wr_addr             = count_ff[IW-1:0];
               wr_data.key         = key_ff;
               wr_data.is_constant = const_ff;
               wr_data.is_integer  = int_ff;
               wr_data.fresh       = 1'b1;
               wr_data.value       = '0;
               cnt_inc             = 1'b1;
               slot_wide           = SW'(count_ff[IW-1:0]);
            end
         end
         tst_pkg::FN_ASSIGN_INT, tst_pkg::FN_ASSIGN_STR: begin
            if (!found_ff) begin
               status   = tst_pkg::RS_UNDECL;
               err_flag = 1'b1;
            end else if ((func_ff == tst_pkg::FN_ASSIGN_INT) != match_ff.is_integer) begin
               status   = tst_pkg::RS_MISMATCH;
               err_flag = 1'b1;
            end else if (match_ff.is_constant && !match_ff.fresh) begin
               status   = tst_pkg::RS_CONST_SET;
               err_flag = 1'b1;
            end else begin
               wr_en         = cmd.commit;
               wr_data.fresh = 1'b0;
               if (func_ff == tst_pkg::FN_ASSIGN_INT) begin
                  wr_data.value = value_ff;
               end
            end
         end
         tst_pkg::FN_READ_INT, tst_pkg::FN_READ_STR: begin
            if (!found_ff) begin
               status   = tst_pkg::RS_UNDECL;
               err_flag = 1'b1;
            end else if ((func_ff == tst_pkg::FN_READ_INT) != match_ff.is_integer) begin
               status   = tst_pkg::RS_MISMATCH;
               err_flag = 1'b1;
            end else if (func_ff == tst_pkg::FN_READ_INT) begin
               vout = match_ff.value;
            end
         end
         tst_pkg::FN_TYPE: begin
            if (!found_ff) begin
               status   = tst_pkg::RS_UNDECL;
               err_flag = 1'b1;
            end else begin
               tout = match_ff.is_integer;
            end
         end
         default: begin
            slot_wide = '0;
         end
      endcase
   end

   // saturating error count
   assign err_in = (err_flag && (err_ff != tst_pkg::ERR_MAX)) ?
                   err_ff + tst_pkg::ERR_W'(1) : err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= '0;
      end else if (cmd.commit) begin
         err_ff <= err_in;
         if (cnt_inc) begin
            count_ff <= count_ff + CW'(1);
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= status;
         rsp_value_ff  <= vout;
         rsp_slot_ff   <= slot_wide[tst_pkg::SLOT_W-1:0];
         rsp_type_ff   <= tout;
         rsp_err_ff    <= err_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_value_out   = $signed(rsp_value_ff);
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_type_out    = rsp_type_ff;
   assign rsp_error_total = rsp_err_ff;

endmodule

`default_nettype wire

// ===== src/tst_checker.sv =====
// port-level checks for the typed symbol table and their bind
`timescale 1ns / 1ps
`default_nettype none

module tst_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_valid,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire logic [2:0]                         rsp_status,
   input wire logic signed [tst_pkg::VALUE_W-1:0] rsp_value_out,
   input wire logic                               rsp_type_out,
   input wire logic [tst_pkg::ERR_W-1:0]          rsp_error_total
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
                                 $stable(rsp_error_total))
      else $error("stalled response changed");

   // no response is produced in the cycle right after a request
   a_no_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("response appeared one cycle after request");

   // failed operations return no value and no type
   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != tst_pkg::RS_OK) |->
         (rsp_value_out == '0) && (rsp_type_out == 1'b0))
      else $error("error response carries data");

   // a semantic error is always counted
   a_err_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == tst_pkg::RS_REDECL) ||
                    (rsp_status == tst_pkg::RS_UNDECL) ||
                    (rsp_status == tst_pkg::RS_MISMATCH) ||
                    (rsp_status == tst_pkg::RS_CONST_SET)) |->
         (rsp_error_total != '0))
      else $error("semantic error not counted");

endmodule

bind typed_symbol_table tst_checker u_tst_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_value_out   (rsp_value_out),
   .rsp_type_out    (rsp_type_out),
   .rsp_error_total (rsp_error_total)
);

`default_nettype wire

// ===== test/typed_symbol_table_tb.sv =====
// self-checking testbench for the typed symbol table
`timescale 1ns / 1ps

module typed_symbol_table_tb;

   localparam int DEPTH      = tst_pkg::TABLE_DEPTH_DEF;
   localparam int KEY_W      = tst_pkg::KEY_W;
   localparam int VALUE_W    = tst_pkg::VALUE_W;
   localparam int SLOT_W     = tst_pkg::SLOT_W;
   localparam int ERR_W      = tst_pkg::ERR_W;
   localparam int KEY_POOL_N = 80;
   localparam int IDLE_LIMIT = 4000;
   localparam int HOLD_LEN   = 300;

   // function codes the block ignores
   localparam logic [2:0] FN_UNUSED_LO = 3'd6;
   localparam logic [2:0] FN_UNUSED_HI = 3'd7;

   localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7fff_ffff;
   localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;

   // fixed identifiers used by the directed tests
   localparam logic [KEY_W-1:0] KEY_ALPHA = KEY_W'("alpha");
   localparam logic [KEY_W-1:0] KEY_NAME  = KEY_W'("name");
   localparam logic [KEY_W-1:0] KEY_TITLE = KEY_W'("title");
   localparam logic [KEY_W-1:0] KEY_GHOST = KEY_W'("ghost");

   // one expected response
   typedef struct packed {
      tst_pkg::status_type       status;
      logic signed [VALUE_W-1:0] value_out;
      logic [SLOT_W-1:0]         slot;
      logic                      type_out;
      logic [ERR_W-1:0]          error_total;
   } symbol_rsp_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [2:0]                req_func = tst_pkg::FN_DECLARE;
   logic [KEY_W-1:0]          req_key = '0;
   logic                      req_is_constant = 1'b0;
   logic                      req_is_integer = 1'b0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [2:0]                rsp_status;
   logic signed [VALUE_W-1:0] rsp_value_out;
   logic [SLOT_W-1:0]         rsp_slot;
   logic                      rsp_type_out;
   logic [ERR_W-1:0]          rsp_error_total;

   // shadow copy of the symbol table
   logic [KEY_W-1:0]          tbl_key   [DEPTH];
   logic                      tbl_const [DEPTH];
   logic                      tbl_int   [DEPTH];
   logic                      tbl_fresh [DEPTH];
   logic signed [VALUE_W-1:0] tbl_value [DEPTH];
   int                        entry_cnt = 0;
   logic [ERR_W-1:0]          err_cnt = '0;

   symbol_rsp_type   awaited_responses[$];
   logic [KEY_W-1:0] key_pool [KEY_POOL_N];
   int               fail_count = 0;
   int               idle_run = 0;
   int               req_idle_pct = 0;
   int               rsp_idle_pct = 0;
   int               stall_hold_request = 0;
   int               stall_hold_left = 0;

   typed_symbol_table #(
      .TABLE_DEPTH(DEPTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_key         (req_key),
      .req_is_constant (req_is_constant),
      .req_is_integer  (req_is_integer),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .rsp_slot        (rsp_slot),
      .rsp_type_out    (rsp_type_out),
      .rsp_error_total (rsp_error_total)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // saturating semantic error count
   function automatic void count_semantic_error();
      if (err_cnt != tst_pkg::ERR_MAX) begin
         err_cnt = err_cnt + 1'b1;
      end
   endfunction

   // apply one request to the shadow table and return its response
   function automatic symbol_rsp_type apply_table_op(input logic [2:0] fn,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic is_const,
                                                     input logic is_int,
                                                     input logic signed [VALUE_W-1:0] val);
      symbol_rsp_type r;
      int             hit;
      r = '0;
      r.status = tst_pkg::RS_OK;
      hit = -1;
      // lowest matching entry wins
      if (fn <= tst_pkg::FN_TYPE) begin
         for (int i = 0; i < entry_cnt; i++) begin
            if (hit < 0 && tbl_key[i] == key) begin
               hit = i;
            end
         end
      end
      if (hit >= 0) begin
         r.slot = hit[SLOT_W-1:0];
      end
      case (fn) inside
         tst_pkg::FN_DECLARE: begin
            if (hit >= 0) begin
               r.status = tst_pkg::RS_REDECL;
               count_semantic_error();
            end else if (entry_cnt >= DEPTH) begin
               r.status = tst_pkg::RS_FULL;
            end else begin
               tbl_key[entry_cnt]   = key;
               tbl_const[entry_cnt] = is_const;
               tbl_int[entry_cnt]   = is_int;
               tbl_fresh[entry_cnt] = 1'b1;
               tbl_value[entry_cnt] = '0;
               r.slot = entry_cnt[SLOT_W-1:0];
               entry_cnt++;
            end
         end
         tst_pkg::FN_ASSIGN_INT, tst_pkg::FN_ASSIGN_STR: begin
            if (hit < 0) begin
               r.status = tst_pkg::RS_UNDECL;
               count_semantic_error();
            end else if ((fn == tst_pkg::FN_ASSIGN_INT) != tbl_int[hit]) begin
               r.status = tst_pkg::RS_MISMATCH;
               count_semantic_error();
            end else if (tbl_const[hit] && !tbl_fresh[hit]) begin
               r.status = tst_pkg::RS_CONST_SET;
               count_semantic_error();
            end else begin
               if (fn == tst_pkg::FN_ASSIGN_INT) begin
                  tbl_value[hit] = val;
               end
               tbl_fresh[hit] = 1'b0;
            end
         end
         tst_pkg::FN_READ_INT, tst_pkg::FN_READ_STR: begin
            if (hit < 0) begin
               r.status = tst_pkg::RS_UNDECL;
               count_semantic_error();
            end else if ((fn == tst_pkg::FN_READ_INT) != tbl_int[hit]) begin
               r.status = tst_pkg::RS_MISMATCH;
               count_semantic_error();
            end else if (fn == tst_pkg::FN_READ_INT) begin
               r.value_out = tbl_value[hit];
            end
         end
         tst_pkg::FN_TYPE: begin
            if (hit < 0) begin
               r.status = tst_pkg::RS_UNDECL;
               count_semantic_error();
            end else begin
               r.type_out = tbl_int[hit];
            end
         end
         default: begin
         end
      endcase
      r.error_total = err_cnt;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      if (fail_count <= 40) begin
         $display("%0t rsp error: %s got %0h expected %0h", $realtime, what, got, want);
      end
   endtask

   // offer one request and wait until it is taken
   task automatic send_request(input logic [2:0] fn, input logic [KEY_W-1:0] key,
                               input logic is_const, input logic is_int,
                               input logic signed [VALUE_W-1:0] val);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_valid       <= 1'b1;
      req_func        <= fn;
      req_key         <= key;
      req_is_constant <= is_const;
      req_is_integer  <= is_int;
      req_value       <= val;
      do @(posedge clock); while (req_stall);
      awaited_responses.push_back(apply_table_op(fn, key, is_const, is_int, val));
   endtask

   task automatic send_random_request();
      logic [2:0]                fn;
      logic [KEY_W-1:0]          key;
      logic signed [VALUE_W-1:0] val;
      int                        pick;
      pick = $urandom_range(0, 99);
      if (pick < 10)      fn = tst_pkg::FN_DECLARE;
      else if (pick < 30) fn = tst_pkg::FN_ASSIGN_INT;
      else if (pick < 45) fn = tst_pkg::FN_ASSIGN_STR;
      else if (pick < 62) fn = tst_pkg::FN_READ_INT;
      else if (pick < 76) fn = tst_pkg::FN_READ_STR;
      else if (pick < 96) fn = tst_pkg::FN_TYPE;
      else                fn = $urandom_range(0, 1) ? FN_UNUSED_HI : FN_UNUSED_LO;
      // mostly keys that can be declared, some never seen before
      if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
      else                           key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
      case ($urandom_range(0, 7))
         0:       val = INT_MAX;
         1:       val = INT_MIN;
         default: val = $urandom;
      endcase
      send_request(fn, key, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), val);
   endtask

   // every function but declare on an empty table, unused codes too
   task automatic test_empty_table();
      send_request(tst_pkg::FN_READ_INT, KEY_ALPHA, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_TYPE, '0, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_ASSIGN_INT, '1, 1'b1, 1'b1, INT_MAX);
      send_request(tst_pkg::FN_ASSIGN_STR, KEY_ALPHA, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_READ_STR, '1, 1'b0, 1'b0, '0);
      send_request(FN_UNUSED_LO, KEY_ALPHA, 1'b1, 1'b1, INT_MIN);
      send_request(FN_UNUSED_HI, '1, 1'b1, 1'b1, INT_MAX);
   endtask

   // types, constants and the errors of declare, assign and read
   task automatic test_declare_and_access();
      send_request(tst_pkg::FN_DECLARE, '1, 1'b0, 1'b1, INT_MAX);
      send_request(tst_pkg::FN_DECLARE, '0, 1'b1, 1'b1, '0);
      send_request(tst_pkg::FN_DECLARE, KEY_NAME, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_DECLARE, KEY_TITLE, 1'b1, 1'b0, '0);
      send_request(tst_pkg::FN_DECLARE, '1, 1'b1, 1'b0, '0);
      send_request(tst_pkg::FN_READ_INT, '1, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_ASSIGN_INT, '1, 1'b0, 1'b0, INT_MAX);
      send_request(tst_pkg::FN_READ_INT, '1, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_ASSIGN_INT, '1, 1'b0, 1'b0, INT_MIN);
      send_request(tst_pkg::FN_READ_INT, '1, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_READ_INT, '0, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_ASSIGN_INT, '0, 1'b0, 1'b0, -32'sd1);
      send_request(tst_pkg::FN_ASSIGN_INT, '0, 1'b0, 1'b0, 32'sd5);
      send_request(tst_pkg::FN_READ_INT, '0, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_ASSIGN_STR, '0, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_READ_STR, '1, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_ASSIGN_STR, KEY_NAME, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_ASSIGN_STR, KEY_NAME, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_READ_STR, KEY_NAME, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_ASSIGN_INT, KEY_TITLE, 1'b0, 1'b0, 32'sd9);
      send_request(tst_pkg::FN_ASSIGN_STR, KEY_TITLE, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_ASSIGN_STR, KEY_TITLE, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_TYPE, '1, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_TYPE, KEY_NAME, 1'b0, 1'b0, '0);
      send_request(FN_UNUSED_HI, '1, 1'b0, 1'b0, '0);
   endtask

   // a run of semantic errors, each adding one to the total
   task automatic test_error_count();
      repeat (8) begin
         send_request(tst_pkg::FN_READ_INT, KEY_GHOST, 1'b0, 1'b0, '0);
      end
      send_request(tst_pkg::FN_ASSIGN_STR, '0, 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_DECLARE, '1, 1'b0, 1'b1, '0);
   endtask

   task automatic test_random_mix(input int n);
      repeat (n) send_random_request();
   endtask

   // receiver holds off while requests keep coming
   task automatic test_backpressure();
      stall_hold_request = HOLD_LEN;
      repeat (10) send_random_request();
   endtask

   // fill every entry, then declare past the end
   task automatic test_full_table();
      while (entry_cnt < DEPTH) begin
         send_request(tst_pkg::FN_DECLARE, {$urandom, $urandom}, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), '0);
      end
      send_request(tst_pkg::FN_DECLARE, {$urandom, $urandom}, 1'b0, 1'b1, '0);
      send_request(tst_pkg::FN_DECLARE, tbl_key[DEPTH-1], 1'b0, 1'b1, '0);
      send_request(tst_pkg::FN_TYPE, tbl_key[DEPTH-1], 1'b0, 1'b0, '0);
      send_request(tst_pkg::FN_READ_INT, tbl_key[DEPTH-1], 1'b0, 1'b0, '0);
   endtask

   // drain, let the block settle, give the verdict
   task automatic finish_run();
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("typed_symbol_table: match");
      end else begin
         $display("typed_symbol_table: mismatch");
      end
      $finish;
   endtask

   // receiver stall, random or held for a long stretch
   always @(posedge clock) begin
      if (stall_hold_request != 0) begin
         stall_hold_left = stall_hold_request;
         stall_hold_request = 0;
      end
      if (stall_hold_left > 0) begin
         stall_hold_left = stall_hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // compare each response with the oldest awaited one
   always @(posedge clock) begin : check_responses
      symbol_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_responses.size() == 0) begin
            report_mismatch("response with no request awaiting", rsp_status, '0);
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_value_out !== want.value_out)
               report_mismatch("value_out", rsp_value_out, want.value_out);
            if (rsp_slot !== want.slot)
               report_mismatch("slot", rsp_slot, want.slot);
            if (rsp_type_out !== want.type_out)
               report_mismatch("type_out", rsp_type_out, want.type_out);
            if (rsp_error_total !== want.error_total)
               report_mismatch("error_total", rsp_error_total, want.error_total);
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_run = 0;
      end else begin
         idle_run++;
         if (idle_run >= IDLE_LIMIT) begin
            $display("typed_symbol_table: mismatch");
            $finish;
         end
      end
   end

   initial begin
      foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct = 27;
      rsp_idle_pct = 52;
      test_empty_table();
      test_declare_and_access();
      test_error_count();
      test_random_mix(580);
      req_idle_pct = 52;
      rsp_idle_pct = 27;
      test_backpressure();
      test_random_mix(580);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_mix(580);
      test_full_table();
      finish_run();
   end

endmodule

// ===== filelist.f =====
src/tst_pkg.sv
src/tst_ctrl.sv
src/tst_datapath.sv
src/typed_symbol_table.sv
src/tst_checker.sv
test/typed_symbol_table_tb.sv
